### src/srt_pkg.sv
// ----------------------------------------------------------------------------
// srt_pkg: shared types and constants of the scoped record table.
// Holds the request and status codes and the bundles between controller and datapath.
// ----------------------------------------------------------------------------
package srt_pkg;

  localparam int unsigned DefScopeDepth   = 16;
  localparam int unsigned DefTableEntries = 64;
  localparam int unsigned DefPayloadBits  = 32;

  typedef enum logic [2:0] {
    REQ_ENTER      = 3'd0,
    REQ_LEAVE      = 3'd1,
    REQ_GET        = 3'd2,
    REQ_BIND       = 3'd3,
    REQ_COPY       = 3'd4,
    REQ_WRITE_BACK = 3'd5,
    REQ_UPDATE     = 3'd6,
    REQ_CLEAR      = 3'd7
  } req_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_EXHAUSTED  = 3'd1,
    ST_ORDER      = 3'd2,
    ST_NOADDR     = 3'd3,
    ST_STACKFULL  = 3'd4,
    ST_TABLEFULL  = 3'd5
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture the request, clear the search results
    logic scan_clr;   // restart the entry index
    logic look_step;  // innermost search on record_addr, one entry
    logic dest_step;  // innermost search on dest_addr, one entry
    logic put_step;   // top-scope match and free search on the put address
    logic drop_step;  // invalidate entries of the closed scope, one entry
    logic rd_look;    // read the entry found by the lookup
    logic rd_wait;    // latch the read data of the lookup entry
    logic do_enter;
    logic do_leave;
    logic wr_back;    // overwrite the innermost destination entry
    logic wr_put;     // write the put slot
    logic fin;        // form the result
  } srt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_last;
    req_e req;
    logic rec_zero;
    logic dst_zero;
    logic no_scope;
    logic stack_full;
    logic exhausted;
    logic tok_match;
    logic look_hit;
    logic dest_hit;
    logic put_ok;
  } srt_stat_t;

endpackage

### src/srt_if.sv
// ----------------------------------------------------------------------------
// srt_req_if / srt_rsp_if: valid/ready channels of the scoped record table.
// One beat carries one request or one result.
// ----------------------------------------------------------------------------
interface srt_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [31:0] record_addr;
  logic [31:0] dest_addr;
  logic [31:0] scope_token;
  logic [31:0] amount_bits;
  logic [31:0] payload_bits;
  modport source (output valid, req_type, record_addr, dest_addr, scope_token,
                  amount_bits, payload_bits, input ready);
  modport sink (input valid, req_type, record_addr, dest_addr, scope_token,
                amount_bits, payload_bits, output ready);
endinterface

interface srt_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] token_out;
  logic        found;
  logic [31:0] amount_out;
  logic [31:0] payload_out;
  logic        updated;
  modport source (output valid, status, token_out, found, amount_out, payload_out,
                  updated, input ready);
  modport sink (input valid, status, token_out, found, amount_out, payload_out,
                updated, output ready);
endinterface

### src/srt_ram.sv
// ----------------------------------------------------------------------------
// srt_ram: generic single-port RAM with registered read.
// One write or one read per cycle.
// ----------------------------------------------------------------------------
module srt_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

### src/srt_datapath.sv
// ----------------------------------------------------------------------------
// srt_datapath: entry table, scope stack and search registers.
// Executes one controller command per cycle and reports flags back.
// ----------------------------------------------------------------------------
module srt_datapath #(
  parameter int unsigned ScopeDepth   = 16,
  parameter int unsigned TableEntries = 64,
  parameter int unsigned PayloadBits  = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  srt_pkg::srt_cmd_t cmd_i,
  output srt_pkg::srt_stat_t stat_o,
  input  logic [2:0]       req_type_i,
  input  logic [31:0]      record_addr_i,
  input  logic [31:0]      dest_addr_i,
  input  logic [31:0]      scope_token_i,
  input  logic [31:0]      amount_bits_i,
  input  logic [31:0]      payload_bits_i,
  output logic [2:0]       status_o,
  output logic [31:0]      token_out_o,
  output logic             found_o,
  output logic [31:0]      amount_out_o,
  output logic [31:0]      payload_out_o,
  output logic             updated_o
);
  import srt_pkg::*;

  localparam int unsigned IdxW = $clog2(TableEntries);
  localparam int unsigned LvlW = (ScopeDepth > 1) ? $clog2(ScopeDepth) : 1;
  localparam int unsigned CntW = $clog2(ScopeDepth + 1);
  localparam int unsigned SIdxW = (ScopeDepth > 1) ? $clog2(ScopeDepth) : 1;
  localparam int unsigned TagW = LvlW + 32 + 1;
  localparam int unsigned ValW = 32 + PayloadBits;

  // Request registers.
  req_e             req_q;
  logic [31:0]      rec_q, dst_q, tok_q, amt_in_q;
  logic [PayloadBits-1:0] pay_in_q;

  // Scope stack.
  logic [31:0]      tcnt_q;
  logic [CntW-1:0]  scnt_q;
  logic [31:0]      stok_q [ScopeDepth];

  // Entry valid bits in flip-flops; tags and values in RAMs.
  logic [TableEntries-1:0] valid_q;
  logic [IdxW-1:0]  idx_q;
  logic             scan_last_q;

  // Search results.
  logic             lk_hit_q, ds_hit_q, mt_hit_q, fr_hit_q;
  logic [IdxW-1:0]  lk_idx_q, ds_idx_q, mt_idx_q, fr_idx_q;
  logic [LvlW-1:0]  lk_lvl_q, ds_lvl_q;
  logic             lk_has_q;
  logic [31:0]      lk_amt_q;
  logic [PayloadBits-1:0] lk_pay_q;

  // Tag RAM pipeline: address idx_q presented, data returns next cycle.
  logic [IdxW-1:0]  tag_addr, val_addr, tag_idx_q;
  logic             tag_we, val_we;
  logic [TagW-1:0]  tag_wdata, tag_rdata;
  logic [ValW-1:0]  val_wdata, val_rdata;
  logic             step_q;
  logic [3:0]       mode_q; // look, dest, put, drop

  logic [LvlW-1:0]  top_lvl;
  logic [31:0]      put_addr;
  logic             put_has;
  logic [31:0]      put_amt;
  logic [PayloadBits-1:0] put_pay;
  logic             src_has;
  logic [LvlW-1:0]  r_lvl;
  logic [31:0]      r_addr;
  logic             r_has;
  logic             r_valid;

  assign top_lvl = LvlW'(scnt_q - CntW'(1));

  srt_ram #(.Width(TagW), .Depth(TableEntries)) u_tag (
    .clk_i, .we_i(tag_we), .addr_i(tag_addr), .wdata_i(tag_wdata),
    .rdata_o(tag_rdata));
  srt_ram #(.Width(ValW), .Depth(TableEntries)) u_val (
    .clk_i, .we_i(val_we), .addr_i(val_addr), .wdata_i(val_wdata),
    .rdata_o(val_rdata));

  assign {r_lvl, r_addr, r_has} = tag_rdata;
  assign r_valid = valid_q[tag_idx_q];
  assign src_has = lk_hit_q && lk_has_q && (rec_q != '0);

  always_comb begin
    put_addr = dst_q;
    put_has  = src_has;
    put_amt  = src_has ? lk_amt_q : '0;
    put_pay  = src_has ? lk_pay_q : '0;
    unique case (req_q)
      REQ_BIND: begin
        put_addr = rec_q; put_has = 1'b1; put_amt = amt_in_q; put_pay = pay_in_q;
      end
      REQ_UPDATE: begin
        put_addr = rec_q; put_has = 1'b1; put_amt = amt_in_q; put_pay = lk_pay_q;
      end
      REQ_CLEAR: begin
        put_addr = rec_q; put_has = 1'b0; put_amt = '0; put_pay = '0;
      end
      default: ;
    endcase
  end

  // RAM port control.
  always_comb begin
    tag_addr  = idx_q;
    val_addr  = idx_q;
    tag_we    = 1'b0;
    val_we    = 1'b0;
    tag_wdata = {top_lvl, put_addr, put_has};
    val_wdata = {put_amt, put_pay};
    if (cmd_i.rd_look) begin
      val_addr = lk_idx_q;
    end else if (cmd_i.wr_back) begin
      tag_addr  = ds_idx_q;
      val_addr  = ds_idx_q;
      tag_we    = 1'b1;
      val_we    = 1'b1;
      tag_wdata = {ds_lvl_q, dst_q, src_has};
    end else if (cmd_i.wr_put) begin
      tag_addr = mt_hit_q ? mt_idx_q : fr_idx_q;
      val_addr = tag_addr;
      tag_we   = 1'b1;
      val_we   = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q    <= req_e'(req_type_i);
      rec_q    <= record_addr_i;
      dst_q    <= dest_addr_i;
      tok_q    <= scope_token_i;
      amt_in_q <= amount_bits_i;
      pay_in_q <= PayloadBits'(payload_bits_i);
    end
    if (cmd_i.do_enter) begin
      stok_q[SIdxW'(scnt_q)] <= tcnt_q + 32'd1;
    end
    if (cmd_i.rd_wait) begin
      lk_amt_q <= val_rdata[ValW-1 -: 32];
      lk_pay_q <= val_rdata[PayloadBits-1:0];
    end
    if (cmd_i.fin) begin
      status_o      <= ST_OK;
      token_out_o   <= '0;
      found_o       <= 1'b0;
      amount_out_o  <= '0;
      payload_out_o <= '0;
      updated_o     <= 1'b0;
      unique case (req_q)
        REQ_ENTER: begin
          if (tcnt_q == '1) status_o <= ST_EXHAUSTED;
          else if (scnt_q >= CntW'(ScopeDepth)) status_o <= ST_STACKFULL;
          else token_out_o <= tcnt_q + 32'd1;
        end
        REQ_LEAVE: begin
          if (!stat_o.tok_match) status_o <= ST_ORDER;
        end
        REQ_GET: begin
          found_o       <= src_has;
          amount_out_o  <= src_has ? lk_amt_q : '0;
          payload_out_o <= src_has ? 32'(lk_pay_q) : '0;
        end
        REQ_BIND, REQ_CLEAR: begin
          if (stat_o.rec_zero || stat_o.no_scope) status_o <= ST_NOADDR;
          else if (!stat_o.put_ok) status_o <= ST_TABLEFULL;
        end
        REQ_COPY: begin
          if (stat_o.dst_zero || stat_o.no_scope) status_o <= ST_NOADDR;
          else if (!stat_o.put_ok) status_o <= ST_TABLEFULL;
        end
        REQ_WRITE_BACK: begin
          if (stat_o.dst_zero || stat_o.no_scope) status_o <= ST_NOADDR;
          else if (!ds_hit_q && !stat_o.put_ok) status_o <= ST_TABLEFULL;
        end
        default: begin
          if (stat_o.rec_zero || stat_o.no_scope) status_o <= ST_NOADDR;
          else if (src_has && !stat_o.put_ok) status_o <= ST_TABLEFULL;
          else updated_o <= src_has;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tcnt_q      <= '0;
      scnt_q      <= '0;
      valid_q     <= '0;
      idx_q       <= '0;
      scan_last_q <= 1'b0;
      step_q      <= 1'b0;
      mode_q      <= '0;
      tag_idx_q   <= '0;
      lk_hit_q    <= 1'b0;
      ds_hit_q    <= 1'b0;
      mt_hit_q    <= 1'b0;
      fr_hit_q    <= 1'b0;
      lk_idx_q    <= '0;
      ds_idx_q    <= '0;
      mt_idx_q    <= '0;
      fr_idx_q    <= '0;
      lk_lvl_q    <= '0;
      ds_lvl_q    <= '0;
      lk_has_q    <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        lk_hit_q <= 1'b0;
        ds_hit_q <= 1'b0;
        mt_hit_q <= 1'b0;
        fr_hit_q <= 1'b0;
      end
      // Issue a tag read; the compare happens in the cycle after.
      step_q    <= cmd_i.look_step | cmd_i.dest_step | cmd_i.put_step | cmd_i.drop_step;
      mode_q    <= {cmd_i.look_step, cmd_i.dest_step, cmd_i.put_step, cmd_i.drop_step};
      tag_idx_q <= idx_q;
      if (cmd_i.scan_clr) begin
        idx_q       <= '0;
        scan_last_q <= 1'b0;
      end else if (cmd_i.look_step | cmd_i.dest_step | cmd_i.put_step |
                   cmd_i.drop_step) begin
        scan_last_q <= (32'(idx_q) == TableEntries - 2) || (TableEntries == 1);
        if (32'(idx_q) != TableEntries - 1) idx_q <= idx_q + IdxW'(1);
      end
      if (step_q && r_valid) begin
        if (mode_q[3] && r_addr == rec_q && (!lk_hit_q || r_lvl > lk_lvl_q)) begin
          lk_hit_q <= 1'b1; lk_idx_q <= tag_idx_q; lk_lvl_q <= r_lvl; lk_has_q <= r_has;
        end
        if (mode_q[2] && r_addr == dst_q && (!ds_hit_q || r_lvl > ds_lvl_q)) begin
          ds_hit_q <= 1'b1; ds_idx_q <= tag_idx_q; ds_lvl_q <= r_lvl;
        end
        if (mode_q[1] && !mt_hit_q && r_addr == put_addr && r_lvl == top_lvl) begin
          mt_hit_q <= 1'b1; mt_idx_q <= tag_idx_q;
        end
        if (mode_q[0] && r_lvl == top_lvl) begin
          valid_q[tag_idx_q] <= 1'b0;
        end
      end
      if (step_q && !r_valid && mode_q[1] && !fr_hit_q) begin
        fr_hit_q <= 1'b1; fr_idx_q <= tag_idx_q;
      end
      if (cmd_i.do_enter) begin
        tcnt_q <= tcnt_q + 32'd1;
        scnt_q <= scnt_q + CntW'(1);
      end
      if (cmd_i.do_leave) begin
        scnt_q <= scnt_q - CntW'(1);
      end
      if (cmd_i.wr_put) begin
        valid_q[mt_hit_q ? mt_idx_q : fr_idx_q] <= 1'b1;
      end
    end
  end

  assign stat_o.scan_last  = scan_last_q;
  assign stat_o.req        = req_q;
  assign stat_o.rec_zero   = (rec_q == '0);
  assign stat_o.dst_zero   = (dst_q == '0);
  assign stat_o.no_scope   = (scnt_q == '0);
  assign stat_o.stack_full = (scnt_q >= CntW'(ScopeDepth));
  assign stat_o.exhausted  = (tcnt_q == '1);
  assign stat_o.tok_match  = (scnt_q != '0) && (stok_q[SIdxW'(top_lvl)] == tok_q);
  assign stat_o.look_hit   = src_has;
  assign stat_o.dest_hit   = ds_hit_q;
  assign stat_o.put_ok     = mt_hit_q | fr_hit_q;
endmodule

### src/srt_ctrl.sv
// ----------------------------------------------------------------------------
// srt_ctrl: request sequencer of the scoped record table.
// Walks the entry table in scan phases and hands the result to the output.
// ----------------------------------------------------------------------------
module srt_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  srt_pkg::srt_stat_t stat_i,
  output srt_pkg::srt_cmd_t  cmd_o
);
  import srt_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_DISP  = 12'b0000_0000_0010,
    S_LOOK  = 12'b0000_0000_0100,
    S_LTAIL = 12'b0000_0000_1000,
    S_RD    = 12'b0000_0001_0000,
    S_RDW   = 12'b0000_0010_0000,
    S_PICK  = 12'b0000_0100_0000,
    S_SCAN2 = 12'b0000_1000_0000,
    S_TAIL2 = 12'b0001_0000_0000,
    S_DEC2  = 12'b0010_0000_0000,
    S_WRITE = 12'b0100_0000_0000,
    S_OUT   = 12'b1000_0000_0000
  } state_e;

  typedef enum logic [1:0] {
    P_DEST = 2'd0,
    P_PUT  = 2'd1,
    P_DROP = 2'd2
  } phase_e;

  state_e state_q, state_d;
  phase_e phase_q, phase_d;
  logic   ovalid_q, ovalid_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = ovalid_q;

  always_comb begin
    state_d  = state_q;
    phase_d  = phase_q;
    ovalid_d = ovalid_q;
    cmd_o    = '0;
    if (ovalid_q && out_ready_i) ovalid_d = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DISP;
        end
      end
      S_DISP: begin
        cmd_o.scan_clr = 1'b1;
        unique case (stat_i.req)
          REQ_ENTER: state_d = S_OUT;
          REQ_LEAVE: begin
            if (stat_i.tok_match) begin
              phase_d = P_DROP;
              state_d = S_SCAN2;
            end else begin
              state_d = S_OUT;
            end
          end
          REQ_BIND, REQ_CLEAR: begin
            if (stat_i.rec_zero || stat_i.no_scope) state_d = S_OUT;
            else begin
              phase_d = P_PUT;
              state_d = S_SCAN2;
            end
          end
          default: state_d = S_LOOK;
        endcase
      end
      S_LOOK: begin
        cmd_o.look_step = 1'b1;
        if (stat_i.scan_last) state_d = S_LTAIL;
      end
      S_LTAIL: state_d = S_RD;
      S_RD: begin
        cmd_o.rd_look = 1'b1;
        state_d       = S_RDW;
      end
      S_RDW: begin
        cmd_o.rd_wait = 1'b1;
        state_d       = S_PICK;
      end
      S_PICK: begin
        cmd_o.scan_clr = 1'b1;
        state_d        = S_SCAN2;
        unique case (stat_i.req)
          REQ_GET: state_d = S_OUT;
          REQ_COPY: begin
            if (stat_i.dst_zero || stat_i.no_scope) state_d = S_OUT;
            else phase_d = P_PUT;
          end
          REQ_WRITE_BACK: begin
            if (stat_i.dst_zero || stat_i.no_scope) state_d = S_OUT;
            else phase_d = P_DEST;
          end
          default: begin
            if (stat_i.rec_zero || stat_i.no_scope || !stat_i.look_hit) state_d = S_OUT;
            else phase_d = P_PUT;
          end
        endcase
      end
      S_SCAN2: begin
        unique case (phase_q)
          P_DEST:  cmd_o.dest_step = 1'b1;
          P_PUT:   cmd_o.put_step  = 1'b1;
          default: cmd_o.drop_step = 1'b1;
        endcase
        if (stat_i.scan_last) state_d = S_TAIL2;
      end
      // The last entry is compared here; the search flags are final in S_DEC2, the cycle after.
      S_TAIL2: state_d = S_DEC2;
      S_DEC2: begin
        if (phase_q == P_DROP) begin
          state_d = S_OUT;
        end else if (phase_q == P_DEST) begin
          if (stat_i.dest_hit) state_d = S_WRITE;
          else begin
            cmd_o.scan_clr = 1'b1;
            phase_d        = P_PUT;
            state_d        = S_SCAN2;
          end
        end else begin
          state_d = stat_i.put_ok ? S_WRITE : S_OUT;
        end
      end
      S_WRITE: begin
        if (phase_q == P_DEST) cmd_o.wr_back = 1'b1;
        else cmd_o.wr_put = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!ovalid_q || out_ready_i) begin
          cmd_o.fin = 1'b1;
          ovalid_d  = 1'b1;
          state_d   = S_IDLE;
          // The stack moves with the result so that it is formed from the old state.
          if (stat_i.req == REQ_ENTER && !stat_i.exhausted && !stat_i.stack_full) begin
            cmd_o.do_enter = 1'b1;
          end
          if (stat_i.req == REQ_LEAVE && stat_i.tok_match) begin
            cmd_o.do_leave = 1'b1;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      phase_q  <= P_PUT;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      phase_q  <= phase_d;
      ovalid_q <= ovalid_d;
    end
  end
endmodule

### src/scoped_record_table_top.sv
// ----------------------------------------------------------------------------
// scoped_record_table_top: nested-scope address-to-value binding table.
// Controller and datapath around one tagged entry table held in RAM.
// ----------------------------------------------------------------------------
// A request beat is taken only while the block is idle, and each request
// yields exactly one result beat. Each scan walks the entry table one entry
// per cycle through the single tag RAM port. Enter and a rejected leave do
// not scan; leave, bind, clear and get scan once (bind and clear not at all
// with a zero address or no open scope); copy and update look up the source
// and then, unless nothing is to be written, scan for the put slot. A
// write-back looks up the source, then searches for the destination and,
// when it is absent, scans once more for a free slot. The result sits in an
// output register, so the next request can be taken while the previous result
// still waits for the consumer; the one after that stalls until the waiting
// beat is taken. Valid bits live in flip-flops and are cleared at reset;
// everything else in the table and the scope-token stack stays unwritten
// until used.
module scoped_record_table_top #(
  parameter int unsigned ScopeDepth   = srt_pkg::DefScopeDepth,
  parameter int unsigned TableEntries = srt_pkg::DefTableEntries,
  parameter int unsigned PayloadBits  = srt_pkg::DefPayloadBits
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  srt_req_if.sink   req_i,
  srt_rsp_if.source rsp_o
);
  import srt_pkg::*;

  srt_cmd_t  cmd;
  srt_stat_t stat;

  // Sequencer: owns both handshakes and steps through the scan phases.
  srt_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Datapath: table RAMs, valid bits, scope stack and the result register.
  srt_datapath #(
    .ScopeDepth   (ScopeDepth),
    .TableEntries (TableEntries),
    .PayloadBits  (PayloadBits)
  ) u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i          (cmd),
    .stat_o         (stat),
    .req_type_i     (req_i.req_type),
    .record_addr_i  (req_i.record_addr),
    .dest_addr_i    (req_i.dest_addr),
    .scope_token_i  (req_i.scope_token),
    .amount_bits_i  (req_i.amount_bits),
    .payload_bits_i (req_i.payload_bits),
    .status_o       (rsp_o.status),
    .token_out_o    (rsp_o.token_out),
    .found_o        (rsp_o.found),
    .amount_out_o   (rsp_o.amount_out),
    .payload_out_o  (rsp_o.payload_out),
    .updated_o      (rsp_o.updated)
  );
endmodule

### tb/scoped_record_table_top_test.sv
// ----------------------------------------------------------------------------
// scoped_record_table_top_test: self-checking test of the scoped record table.
// Drives request beats with random gaps and back-pressure, predicts every
// result with a behavioral copy of the scope stack and the entry table, and
// compares each result beat field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module scoped_record_table_top_test;
  import srt_pkg::*;

  localparam int unsigned Depth   = DefScopeDepth;
  localparam int unsigned Entries = DefTableEntries;
  localparam int unsigned Limit   = 2_000_000;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] token_out;
    logic        found;
    logic [31:0] amount_out;
    logic [31:0] payload_out;
    logic        updated;
  } result_t;

  logic clk_i;
  logic rst_ni;

  srt_req_if req_if ();
  srt_rsp_if rsp_if ();

  scoped_record_table_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if.sink),
    .rsp_o  (rsp_if.source)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Behavioral copy of the block's state.
  logic [31:0] tok_ctr;
  logic [31:0] tok_stack [Depth];
  int unsigned open_scopes;
  logic        ent_vld [Entries];
  int unsigned ent_lvl [Entries];
  logic [31:0] ent_addr [Entries];
  logic        ent_has [Entries];
  logic [31:0] ent_amt [Entries];
  logic [31:0] ent_pay [Entries];

  result_t     expected_results[$];
  int unsigned mismatches;
  int unsigned results_seen;
  longint unsigned cycle_count;
  int unsigned sent_count;
  int unsigned op_count [8];

  // Handshake shaping controls.
  bit          idle_enable;
  bit          hold_rx;
  logic [31:0] tokens_open [$];  // tokens the stimulus believes are open

  function automatic int find_innermost(logic [31:0] addr);
    int best;
    best = -1;
    for (int i = 0; i < Entries; i++)
      if (ent_vld[i] && ent_addr[i] == addr && (best < 0 || ent_lvl[i] > ent_lvl[best]))
        best = i;
    return best;
  endfunction

  function automatic bit find_value(logic [31:0] addr, output logic [31:0] amt,
                                    output logic [31:0] pay);
    int i;
    amt = '0;
    pay = '0;
    if (addr == 0) return 1'b0;
    i = find_innermost(addr);
    if (i < 0 || !ent_has[i]) return 1'b0;
    amt = ent_amt[i];
    pay = ent_pay[i];
    return 1'b1;
  endfunction

  function automatic status_e write_top(logic [31:0] addr, bit has, logic [31:0] amt,
                                        logic [31:0] pay);
    int slot;
    int unsigned top;
    top  = open_scopes - 1;
    slot = -1;
    for (int i = 0; i < Entries && slot < 0; i++)
      if (ent_vld[i] && ent_lvl[i] == top && ent_addr[i] == addr) slot = i;
    for (int i = 0; i < Entries && slot < 0; i++)
      if (!ent_vld[i]) slot = i;
    if (slot < 0) return ST_TABLEFULL;
    ent_vld[slot]  = 1'b1;
    ent_lvl[slot]  = top;
    ent_addr[slot] = addr;
    ent_has[slot]  = has;
    ent_amt[slot]  = has ? amt : '0;
    ent_pay[slot]  = has ? pay : '0;
    return ST_OK;
  endfunction

  // Computes the result of one request and advances the state copy.
  function automatic result_t predict_table_result(req_e req, logic [31:0] rec,
      logic [31:0] dst, logic [31:0] tok, logic [31:0] amt_in, logic [31:0] pay_in);
    result_t r;
    logic [31:0] amt, pay;
    bit has;
    int i;
    r = '0;
    r.status = ST_OK;
    case (req)
      REQ_ENTER: begin
        if (tok_ctr == '1) begin
          r.status = ST_EXHAUSTED;
        end else if (open_scopes >= Depth) begin
          r.status = ST_STACKFULL;
        end else begin
          tok_ctr = tok_ctr + 1;
          tok_stack[open_scopes] = tok_ctr;
          open_scopes++;
          r.token_out = tok_ctr;
        end
      end
      REQ_LEAVE: begin
        if (open_scopes == 0 || tok_stack[open_scopes-1] != tok) begin
          r.status = ST_ORDER;
        end else begin
          open_scopes--;
          for (int k = 0; k < Entries; k++)
            if (ent_vld[k] && ent_lvl[k] == open_scopes) ent_vld[k] = 1'b0;
        end
      end
      REQ_GET: begin
        r.found = find_value(rec, amt, pay);
        r.amount_out  = amt;
        r.payload_out = pay;
      end
      REQ_BIND, REQ_CLEAR: begin
        if (rec == 0 || open_scopes == 0) r.status = ST_NOADDR;
        else if (req == REQ_BIND) r.status = write_top(rec, 1'b1, amt_in, pay_in);
        else r.status = write_top(rec, 1'b0, '0, '0);
      end
      REQ_COPY: begin
        has = find_value(rec, amt, pay);
        if (dst == 0 || open_scopes == 0) r.status = ST_NOADDR;
        else r.status = write_top(dst, has, amt, pay);
      end
      REQ_WRITE_BACK: begin
        has = find_value(rec, amt, pay);
        if (dst == 0 || open_scopes == 0) begin
          r.status = ST_NOADDR;
        end else begin
          i = find_innermost(dst);
          if (i >= 0) begin
            ent_has[i] = has;
            ent_amt[i] = amt;
            ent_pay[i] = pay;
          end else begin
            r.status = write_top(dst, has, amt, pay);
          end
        end
      end
      default: begin  // update
        if (rec == 0 || open_scopes == 0) begin
          r.status = ST_NOADDR;
        end else if (find_value(rec, amt, pay)) begin
          r.status  = write_top(rec, 1'b1, amt_in, pay);
          r.updated = (r.status == ST_OK);
        end
      end
    endcase
    return r;
  endfunction

  // Sends one request beat; the prediction is made when the beat is taken.
  // Valid stays high after the beat is taken until the next beat or a pause;
  // the block stays busy after each beat until it has formed the result.
  task automatic send_request(req_e req, logic [31:0] rec, logic [31:0] dst,
                              logic [31:0] tok, logic [31:0] amt, logic [31:0] pay);
    result_t r;
    int gap;
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 16);
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.valid        <= 1'b1;
    req_if.req_type     <= req;
    req_if.record_addr  <= rec;
    req_if.dest_addr    <= dst;
    req_if.scope_token  <= tok;
    req_if.amount_bits  <= amt;
    req_if.payload_bits <= pay;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    r = predict_table_result(req, rec, dst, tok, amt, pay);
    expected_results.insert(expected_results.size(), r);
    // Track the stimulus-side view of open scopes for well-formed leaves.
    if (req == REQ_ENTER && r.status == ST_OK)
      tokens_open.insert(tokens_open.size(), r.token_out);
    if (req == REQ_LEAVE && r.status == ST_OK && tokens_open.size() != 0)
      tokens_open.delete(tokens_open.size() - 1);
    sent_count++;
    op_count[req]++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk_i);
  endtask

  // Result side: random stalls, plus a long hold-off when asked.
  always @(negedge clk_i) begin
    if (!rst_ni || hold_rx) begin
      rsp_if.ready <= 1'b0;
    end else if (idle_enable && $urandom_range(0, 7) == 0) begin
      rsp_if.ready <= 1'b0;
      repeat ($urandom_range(1, 16) - 1) @(negedge clk_i);
    end else begin
      rsp_if.ready <= 1'b1;
    end
  end

  // Result checker.
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result beat at cycle %0d", cycle_count);
      end else begin
        want = expected_results.pop_front();
        if (rsp_if.status !== want.status || rsp_if.token_out !== want.token_out ||
            rsp_if.found !== want.found || rsp_if.amount_out !== want.amount_out ||
            rsp_if.payload_out !== want.payload_out || rsp_if.updated !== want.updated) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Result %0d: expected st=%0d tok=%h f=%b amt=%h pay=%h u=%b",
                     results_seen, want.status, want.token_out, want.found,
                     want.amount_out, want.payload_out, want.updated);
            $display("  got st=%0d tok=%h f=%b amt=%h pay=%h u=%b",
                     rsp_if.status, rsp_if.token_out, rsp_if.found, rsp_if.amount_out,
                     rsp_if.payload_out, rsp_if.updated);
          end
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > Limit) begin
      $display("Timeout at cycle %0d with %0d results outstanding", cycle_count,
               expected_results.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // Small address pool so that bindings collide, shadow and get found.
  function automatic logic [31:0] pick_addr();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return $urandom();
      default: return $urandom_range(1, 12);
    endcase
  endfunction

  function automatic logic [31:0] pick_data();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return $urandom();
    endcase
  endfunction

  // Token for leave: mostly the right one, sometimes a wrong one.
  function automatic logic [31:0] pick_token();
    if (tokens_open.size() != 0 && $urandom_range(0, 5) != 0)
      return tokens_open[tokens_open.size()-1];
    return $urandom_range(0, 1) ? $urandom() : tok_ctr;
  endfunction

  task automatic send_random(int unsigned leave_weight);
    int unsigned pick;
    req_e req;
    pick = $urandom_range(0, 99);
    if (pick < 8 + (open_scopes < 3 ? 12 : 0)) req = REQ_ENTER;
    else if (pick < 8 + leave_weight) req = REQ_LEAVE;
    else req = req_e'($urandom_range(2, 7));
    send_request(req, pick_addr(), pick_addr(), pick_token(), pick_data(), pick_data());
  endtask

  // Directed: every request, zero addresses, no-scope errors, bad leaves,
  // shadowing by a cleared binding, copies of absent sources, update misses.
  task automatic test_directed();
    send_request(REQ_GET, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    send_request(REQ_BIND, 32'd5, 32'd0, 32'd0, 32'd1, 32'd2);
    send_request(REQ_CLEAR, 32'd5, 32'd0, 32'd0, 32'd0, 32'd0);
    send_request(REQ_COPY, 32'd5, 32'd6, 32'd0, 32'd0, 32'd0);
    send_request(REQ_WRITE_BACK, 32'd5, 32'd6, 32'd0, 32'd0, 32'd0);
    send_request(REQ_UPDATE, 32'd5, 32'd0, 32'd0, 32'd1, 32'd0);
    send_request(REQ_LEAVE, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    send_request(REQ_ENTER, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    send_request(REQ_BIND, '1, 32'd0, 32'd0, '1, '1);
    send_request(REQ_BIND, 32'd0, 32'd0, 32'd0, 32'd3, 32'd3);
    send_request(REQ_ENTER, '1, '1, '1, '1, '1);
    send_request(REQ_GET, '1, 32'd0, 32'd0, 32'd0, 32'd0);
    send_request(REQ_CLEAR, '1, 32'd0, 32'd0, 32'd0, 32'd0);
    send_request(REQ_GET, '1, 32'd0, 32'd0, 32'd0, 32'd0);
    send_request(REQ_COPY, 32'd9, 32'd7, 32'd0, 32'd0, 32'd0);
    send_request(REQ_COPY, '1, 32'd0, 32'd0, 32'd0, 32'd0);
    send_request(REQ_WRITE_BACK, 32'd0, '1, 32'd0, 32'd0, 32'd0);
    send_request(REQ_UPDATE, '1, 32'd0, 32'd0, 32'hA5A5_5A5A, 32'd0);
    send_request(REQ_UPDATE, 32'd9, 32'd0, 32'd0, 32'd1, 32'd0);
    send_request(REQ_LEAVE, 32'd0, 32'd0, 32'd1, 32'd0, 32'd0);
    send_request(REQ_LEAVE, 32'd0, 32'd0, 32'd2, 32'd0, 32'd0);
    send_request(REQ_GET, '1, 32'd0, 32'd0, 32'd0, 32'd0);
    send_request(REQ_LEAVE, 32'd0, 32'd0, 32'd1, 32'd0, 32'd0);
    wait_drained();
  endtask

  // Stack full: open scopes past the depth, then close them all.
  task automatic test_stack_full();
    repeat (Depth + 2) send_request(REQ_ENTER, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    send_request(REQ_BIND, 32'd3, 32'd0, 32'd0, 32'd7, 32'd8);
    while (tokens_open.size() != 0)
      send_request(REQ_LEAVE, 32'd0, 32'd0, tokens_open[tokens_open.size()-1], 32'd0, 32'd0);
    wait_drained();
  endtask

  // Table full: bind distinct addresses past the capacity across two scopes.
  task automatic test_table_full();
    send_request(REQ_ENTER, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    for (int i = 1; i <= Entries / 2; i++)
      send_request(REQ_BIND, i, 32'd0, 32'd0, $urandom(), $urandom());
    send_request(REQ_ENTER, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    for (int i = 1; i <= Entries / 2 + 3; i++)
      send_request(REQ_BIND, 32'h100 + i, 32'd0, 32'd0, $urandom(), $urandom());
    send_request(REQ_CLEAR, 32'd999, 32'd0, 32'd0, 32'd0, 32'd0);
    send_request(REQ_COPY, 32'd1, 32'd998, 32'd0, 32'd0, 32'd0);
    send_request(REQ_UPDATE, 32'd1, 32'd0, 32'd0, 32'd5, 32'd0);
    send_request(REQ_WRITE_BACK, 32'd2, 32'd997, 32'd0, 32'd0, 32'd0);
    send_request(REQ_WRITE_BACK, 32'd2, 32'd3, 32'd0, 32'd0, 32'd0);
    send_request(REQ_GET, 32'd3, 32'd0, 32'd0, 32'd0, 32'd0);
    while (tokens_open.size() != 0)
      send_request(REQ_LEAVE, 32'd0, 32'd0, tokens_open[tokens_open.size()-1], 32'd0, 32'd0);
    wait_drained();
  endtask

  // Long receiver hold-off while the sender keeps offering beats.
  task automatic test_backpressure();
    fork
      begin
        hold_rx = 1'b1;
        repeat (600) @(negedge clk_i);
        hold_rx = 1'b0;
      end
      repeat (12) send_random(10);
    join
    wait_drained();
  endtask

  // Mostly well-formed nesting with random content, plus noise.
  task automatic test_random(int unsigned count);
    for (int n = 0; n < count; n++) begin
      send_random(open_scopes > 6 ? 14 : 6);
      if (n == count / 2) wait_drained();  // sender pauses until all results are back
    end
    wait_drained();
  endtask

  initial begin
    rst_ni              = 1'b0;
    req_if.valid        = 1'b0;
    req_if.req_type     = REQ_GET;
    req_if.record_addr  = '0;
    req_if.dest_addr    = '0;
    req_if.scope_token  = '0;
    req_if.amount_bits  = '0;
    req_if.payload_bits = '0;
    rsp_if.ready        = 1'b0;
    idle_enable         = 1'b1;
    hold_rx             = 1'b0;
    mismatches          = 0;
    results_seen        = 0;
    cycle_count         = 0;
    sent_count          = 0;
    tok_ctr             = '0;
    open_scopes         = 0;
    foreach (op_count[k]) op_count[k] = 0;
    foreach (ent_vld[k]) ent_vld[k] = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    test_stack_full();
    test_table_full();
    test_backpressure();
    test_random(800);
    // Last stretch runs with no idling on either side.
    idle_enable = 1'b0;
    test_random(200);

    repeat (2 * Entries + 20) @(negedge clk_i);
    $display("Sent %0d requests (enter %0d, leave %0d, get %0d, bind %0d, copy %0d,",
             sent_count, op_count[0], op_count[1], op_count[2], op_count[3], op_count[4]);
    $display("  write-back %0d, update %0d, clear %0d); %0d results checked.",
             op_count[5], op_count[6], op_count[7], results_seen);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, expected_results.size());
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
